@@ hw/rtl/ibma_pkg.sv @@
// shared types and constants for the inode bitmap allocator
// used by the top level, the zero finder and the port checker

package ibma_pkg;

    // storage geometry
    localparam int MAX_GROUPS      = 16;
    localparam int MAX_PER_GROUP   = 1024;
    localparam int WORD_BITS       = 32;
    localparam int WORDS_PER_GROUP = (MAX_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL_WORDS     = MAX_GROUPS * WORDS_PER_GROUP;

    localparam int GROUP_W = $clog2(MAX_GROUPS);
    localparam int WSEL_W  = $clog2(WORDS_PER_GROUP);
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int ADDR_W  = $clog2(TOTAL_WORDS);

    // field widths
    localparam int PPG_W = 11;
    localparam int GC_W  = 5;
    localparam int NUM_W = 15;
    localparam int ST_W  = 2;

    // reset values of the configuration registers
    localparam logic [PPG_W-1:0] PPG_RESET = PPG_W'(MAX_PER_GROUP);
    localparam logic [GC_W-1:0]  GC_RESET  = GC_W'(MAX_GROUPS);
    localparam logic [NUM_W-1:0] FF_RESET  = 15'd11;

    // configuration register indexes
    localparam logic [1:0] CFG_PER_GROUP  = 2'd0;
    localparam logic [1:0] CFG_GROUPS     = 2'd1;
    localparam logic [1:0] CFG_FIRST_FREE = 2'd2;

    // request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [ST_W-1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] STATUS_IGNORED = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_GROUP,
        ST_A_READ,
        ST_A_TEST,
        ST_F_DIV,
        ST_F_READ,
        ST_F_TEST,
        ST_DONE
    } state_t;

    // result of the lowest clear bit search
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } find_t;

endpackage

@@ hw/rtl/inode_bitmap_allocator.sv @@
// inode bitmap allocator: group bitmap with first fit and wrap-around group search
// depends on ibma_pkg and ibma_zero_find
//
// one request at a time; s_tready is high only while the sequencer is idle
// allocate: full groups are skipped by their count; in each other group the bitmap words
//   are read and tested one by one from word 0 until a clear bit is found
// free: the group is found by repeated subtraction, then the word is read and tested
// reset clears counts at once, then a sweep zeroes all 512 words of the bitmap memory
//   one word at a time before the first request is taken

module inode_bitmap_allocator
    import ibma_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [NUM_W-1:0]  cfg_data,
    // request stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // home_group[3:0], release_number[18:4], zero pad
    input  logic [0:0]        s_tuser,   // func[0]
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // granted_number[14:0], free_total[29:15], zero pad
    output logic [ST_W-1:0]   m_tuser    // status[1:0]
);

    // configuration registers
    logic [PPG_W-1:0] per_group_count_reg;
    logic [GC_W-1:0]  group_count_reg;
    logic [NUM_W-1:0] first_freeable_reg;

    // sequencer and datapath registers
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [GROUP_W-1:0] g_reg, g_next;
    logic [WSEL_W-1:0] w_reg, w_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [GC_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [NUM_W-1:0]  granted_reg, granted_next;
    logic [NUM_W-1:0]  total_used_reg, total_used_next;
    logic [NUM_W-1:0]  cap_reg;
    logic [PPG_W-1:0]  group_used_reg [MAX_GROUPS];
    logic              gu_we;
    logic [PPG_W-1:0]  gu_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [ST_W-1:0]   m_status_reg, m_status_next;
    logic [NUM_W-1:0]  m_granted_reg, m_granted_next;
    logic [NUM_W-1:0]  m_free_reg, m_free_next;

    // bitmap memory
    logic [WORD_BITS-1:0] bitmap_mem [TOTAL_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;

    // derived values
    logic [PPG_W-1:0]   ppg_eff, ppg_m1;
    logic [GC_W-1:0]    gc_eff;
    logic [WSEL_W-1:0]  last_word;
    logic [BIT_W-1:0]   lim;
    logic [PPG_W-1:0]   gu_cur;
    logic               grp_full;
    logic [GC_W-1:0]    g_inc;
    logic [GROUP_W-1:0] g_adv;
    logic               last_group;
    logic               s_fire, out_ready;
    logic               in_func;
    logic [GROUP_W-1:0] in_start, start_eff;
    logic [NUM_W-1:0]   in_rel;
    logic               free_ok;
    logic               rem_lt;
    logic [GC_W-1:0]    quo_inc;
    logic               bit_set;
    logic [NUM_W-1:0]   out_free;
    logic [NUM_W-1:0]   grant_calc;
    find_t              find;

    // effective configuration: zero per-group acts as one, oversize values clamp
    always_comb
    begin
        if (per_group_count_reg == '0)
            ppg_eff = PPG_W'(1);
        else if (per_group_count_reg > PPG_W'(MAX_PER_GROUP))
            ppg_eff = PPG_W'(MAX_PER_GROUP);
        else
            ppg_eff = per_group_count_reg;
        if (group_count_reg > GC_W'(MAX_GROUPS))
            gc_eff = GC_W'(MAX_GROUPS);
        else
            gc_eff = group_count_reg;
    end

    assign ppg_m1    = ppg_eff - PPG_W'(1);
    assign last_word = ppg_m1[BIT_W +: WSEL_W];
    assign lim       = (w_reg == last_word) ? ppg_m1[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);

    // group bookkeeping
    assign gu_cur     = group_used_reg[g_reg];
    assign grp_full   = (gu_cur >= ppg_eff);
    assign g_inc      = {1'b0, g_reg} + GC_W'(1);
    assign g_adv      = (g_inc == gc_eff) ? '0 : g_inc[GROUP_W-1:0];
    assign last_group = (cnt_reg == GC_W'(1));

    // handshakes and request fields
    assign s_fire    = s_tvalid && s_tready;
    assign out_ready = !m_valid_reg || m_tready;
    assign in_func   = s_tuser[0];
    assign in_start  = s_tdata[3:0];
    assign in_rel    = s_tdata[18:4];
    assign start_eff = ({1'b0, in_start} >= gc_eff) ? '0 : in_start;
    assign free_ok   = (in_rel != '0) && (in_rel >= first_freeable_reg) && (gc_eff != '0);

    // repeated subtraction finds the group of a released number
    assign rem_lt  = (rem_reg < {{(NUM_W-PPG_W){1'b0}}, ppg_eff});
    assign quo_inc = cnt_reg + GC_W'(1);
    assign bit_set = rd_data_reg[bit_reg];

    // granted number from group, word and bit
    assign grant_calc = NUM_W'(NUM_W'(g_reg) * NUM_W'(ppg_eff))
                      + NUM_W'({w_reg, find.pos}) + NUM_W'(1);

    // free count, floored at zero
    assign out_free = (cap_reg > total_used_reg) ? (cap_reg - total_used_reg) : '0;

    ibma_zero_find u_find (
        .word   (rd_data_reg),
        .lim    (lim),
        .result (find)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_fire)
                begin
                    if (in_func == FUNC_ALLOC)
                        state_next = (gc_eff == '0) ? ST_DONE : ST_A_GROUP;
                    else
                        state_next = free_ok ? ST_F_DIV : ST_DONE;
                end
            ST_A_GROUP:
                if (grp_full)
                    state_next = last_group ? ST_DONE : ST_A_GROUP;
                else
                    state_next = ST_A_READ;
            ST_A_READ:
                state_next = ST_A_TEST;
            ST_A_TEST:
                if (find.found)
                    state_next = ST_DONE;
                else if (w_reg == last_word)
                    state_next = last_group ? ST_DONE : ST_A_GROUP;
                else
                    state_next = ST_A_READ;
            ST_F_DIV:
                if (rem_lt)
                    state_next = ST_F_READ;
                else if (quo_inc == gc_eff)
                    state_next = ST_DONE;
            ST_F_READ:
                state_next = ST_F_TEST;
            ST_F_TEST:
                state_next = ST_DONE;
            ST_DONE:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and output values
    always_comb
    begin
        clr_next        = clr_reg;
        g_next          = g_reg;
        w_next          = w_reg;
        bit_next        = bit_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        total_used_next = total_used_reg;
        gu_we           = 1'b0;
        gu_next         = gu_cur;
        mem_we          = 1'b0;
        mem_wdata       = rd_data_reg;
        mem_addr        = {g_reg, w_reg};
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_granted_next  = m_granted_reg;
        m_free_next     = m_free_reg;
        s_tready        = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
            end
            ST_IDLE:
                if (s_fire)
                begin
                    granted_next = '0;
                    w_next       = '0;
                    if (in_func == FUNC_ALLOC)
                    begin
                        status_next = STATUS_NOSPACE;
                        g_next      = start_eff;
                        cnt_next    = gc_eff;
                    end
                    else
                    begin
                        status_next = STATUS_IGNORED;
                        rem_next    = in_rel - NUM_W'(1);
                        cnt_next    = '0;
                    end
                end
            ST_A_GROUP:
            begin
                w_next = '0;
                if (grp_full)
                begin
                    g_next   = g_adv;
                    cnt_next = cnt_reg - GC_W'(1);
                end
            end
            ST_A_READ:
                ;
            ST_A_TEST:
                if (find.found)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = rd_data_reg | (WORD_BITS'(1) << find.pos);
                    gu_we           = 1'b1;
                    gu_next         = gu_cur + PPG_W'(1);
                    total_used_next = total_used_reg + NUM_W'(1);
                    granted_next    = grant_calc;
                    status_next     = STATUS_OK;
                end
                else if (w_reg == last_word)
                begin
                    g_next   = g_adv;
                    cnt_next = cnt_reg - GC_W'(1);
                    w_next   = '0;
                end
                else
                    w_next = w_reg + WSEL_W'(1);
            ST_F_DIV:
                if (rem_lt)
                begin
                    g_next   = cnt_reg[GROUP_W-1:0];
                    w_next   = rem_reg[BIT_W +: WSEL_W];
                    bit_next = rem_reg[BIT_W-1:0];
                end
                else
                begin
                    rem_next = rem_reg - {{(NUM_W-PPG_W){1'b0}}, ppg_eff};
                    cnt_next = quo_inc;
                end
            ST_F_READ:
                ;
            ST_F_TEST:
                if (bit_set)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = rd_data_reg & ~(WORD_BITS'(1) << bit_reg);
                    status_next = STATUS_OK;
                    if (gu_cur != '0)
                    begin
                        gu_we   = 1'b1;
                        gu_next = gu_cur - PPG_W'(1);
                    end
                    if (total_used_reg != '0)
                        total_used_next = total_used_reg - NUM_W'(1);
                end
            ST_DONE:
                if (out_ready)
                begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_granted_next = granted_reg;
                    m_free_next    = out_free;
                end
            default:
                ;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_group_count_reg <= PPG_RESET;
            group_count_reg     <= GC_RESET;
            first_freeable_reg  <= FF_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PER_GROUP)
                per_group_count_reg <= cfg_data[PPG_W-1:0];
            if (cfg_index == CFG_GROUPS)
                group_count_reg <= cfg_data[GC_W-1:0];
            if (cfg_index == CFG_FIRST_FREE)
                first_freeable_reg <= cfg_data;
        end
    end

    // control state and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            total_used_reg <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_GROUPS; i++)
                group_used_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            total_used_reg <= total_used_next;
            m_valid_reg    <= m_valid_next;
            if (gu_we)
                group_used_reg[g_reg] <= gu_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        g_reg         <= g_next;
        w_reg         <= w_next;
        bit_reg       <= bit_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        m_status_reg  <= m_status_next;
        m_granted_reg <= m_granted_next;
        m_free_reg    <= m_free_next;
        cap_reg       <= NUM_W'(NUM_W'(gc_eff) * NUM_W'(ppg_eff));
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bitmap_mem[mem_addr] <= mem_wdata;
        rd_data_reg <= bitmap_mem[mem_addr];
    end

    // result port
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_free_reg, m_granted_reg};

endmodule

@@ hw/rtl/ibma_zero_find.sv @@
// lowest clear bit search over one bitmap word, limited to bits 0..lim
// depends on ibma_pkg for word width and the find_t result type

module ibma_zero_find
    import ibma_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    input  logic [BIT_W-1:0]     lim,
    output find_t                result
);

    // scan from the top so the lowest qualifying bit wins
    always_comb
    begin
        result.found = 1'b0;
        result.pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i] && (BIT_W'(i) <= lim))
            begin
                result.found = 1'b1;
                result.pos   = BIT_W'(i);
            end
        end
    end

endmodule

@@ hw/rtl/ibma_checker.sv @@
// port-level checks for the inode bitmap allocator
// depends on ibma_pkg; bound to the top level at the end of this file

module ibma_checker
    import ibma_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [31:0]     m_tdata,
    input logic [ST_W-1:0] m_tuser
);

    // a stalled result word holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one request at a time: no new word right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // only the three defined status codes appear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_OK) || (m_tuser == STATUS_NOSPACE)
                     || (m_tuser == STATUS_IGNORED))
        else $error("undefined status code");

    // a failed or ignored request never grants a number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata[NUM_W-1:0] == '0))
        else $error("number granted on a failed request");

    // free count never exceeds the largest capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2*NUM_W-1:NUM_W] <= NUM_W'(MAX_GROUPS * MAX_PER_GROUP)))
        else $error("free count above capacity");

endmodule

bind inode_bitmap_allocator ibma_checker u_ibma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// testbench for inode_bitmap_allocator: directed and random allocate/free traffic
// each result word is checked against a bitmap predictor kept here; needs ibma_pkg and the rtl

module tb;
    import ibma_pkg::*;

    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int SETTLE_CYCLES = 4;

    // one result word split into its fields
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [NUM_W-1:0] granted;
        logic [NUM_W-1:0] free_left;
    } reply_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [NUM_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;   // home_group[3:0], release_number[18:4], zero pad
    logic [0:0]        s_tuser;   // func[0]
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // granted_number[14:0], free_total[29:15], zero pad
    logic [ST_W-1:0]   m_tuser;   // status[1:0]

    // predictor copy of the registers and the allocation state
    logic [PPG_W-1:0]  ppg_reg;
    logic [GC_W-1:0]   gc_reg;
    logic [NUM_W-1:0]  ff_reg;
    bit                usage_map [MAX_GROUPS][MAX_PER_GROUP];
    int unsigned       group_fill [MAX_GROUPS];
    int unsigned       used_total;

    reply_t            grant_replies[$];
    int unsigned       held_inodes[$];
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       stall_left = 0;
    bit                traffic_gaps = 1'b1;

    inode_bitmap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // effective per-group size: 0 acts as 1, clamp at the storage size
    function automatic int unsigned eff_per_group();
        if (ppg_reg == '0)
            return 1;
        if (ppg_reg > MAX_PER_GROUP)
            return MAX_PER_GROUP;
        return ppg_reg;
    endfunction

    function automatic int unsigned eff_groups();
        if (gc_reg > MAX_GROUPS)
            return MAX_GROUPS;
        return gc_reg;
    endfunction

    // free numbers left in the active groups, floored at zero
    function automatic int unsigned free_left_now();
        int unsigned cap;
        cap = eff_groups() * eff_per_group();
        if (cap <= used_total)
            return 0;
        if (cap - used_total > 32767)
            return 32767;
        return cap - used_total;
    endfunction

    // take the lowest clear bit below ppg in one group, skipping a full group
    function automatic bit claim_lowest(input int unsigned g, input int unsigned ppg,
                                        output int unsigned pos);
        int unsigned b;
        pos = 0;
        if (group_fill[g] >= ppg)
            return 1'b0;
        for (b = 0; b < ppg; b++)
        begin
            if (!usage_map[g][b])
            begin
                usage_map[g][b] = 1'b1;
                group_fill[g]++;
                used_total++;
                pos = b;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // allocate or free one inode number and build the reply word
    function automatic reply_t apply_inode_request(input logic fn, input logic [3:0] sg,
                                                   input logic [NUM_W-1:0] rel);
        reply_t      r;
        int unsigned ppg;
        int unsigned gc;
        int unsigned start;
        int unsigned k;
        int unsigned g;
        int unsigned pos;
        int unsigned idx;
        int unsigned slot;
        bit          found;
        ppg = eff_per_group();
        gc = eff_groups();
        r.status = STATUS_IGNORED;
        r.granted = '0;
        found = 1'b0;
        if (fn == FUNC_ALLOC)
        begin
            // out-of-range start group searches from group 0
            start = sg;
            if (start >= gc)
                start = 0;
            // start group up to the last, then wrap from group 0
            for (k = 0; k < gc && !found; k++)
            begin
                g = (start + k) % gc;
                if (claim_lowest(g, ppg, pos))
                begin
                    r.granted = NUM_W'(g * ppg + pos + 1);
                    found = 1'b1;
                end
            end
            r.status = found ? STATUS_OK : STATUS_NOSPACE;
        end
        else if (rel != '0 && rel >= ff_reg)
        begin
            idx = rel - 1;
            g = idx / ppg;
            slot = idx % ppg;
            if (g < gc)
            begin
                if (usage_map[g][slot])
                begin
                    usage_map[g][slot] = 1'b0;
                    if (group_fill[g] > 0)
                        group_fill[g]--;
                    if (used_total > 0)
                        used_total--;
                    r.status = STATUS_OK;
                end
            end
        end
        r.free_left = NUM_W'(free_left_now());
        return r;
    endfunction

    task automatic reset_predictor();
        ppg_reg = PPG_RESET;
        gc_reg = GC_RESET;
        ff_reg = FF_RESET;
        foreach (usage_map[g, b])
            usage_map[g][b] = 1'b0;
        foreach (group_fill[g])
            group_fill[g] = 0;
        used_total = 0;
    endtask

    // one register write, then the write enable is dropped again
    task automatic write_reg(input logic [1:0] idx, input logic [NUM_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_PER_GROUP:  ppg_reg = value[PPG_W-1:0];
            CFG_GROUPS:     gc_reg = value[GC_W-1:0];
            CFG_FIRST_FREE: ff_reg = value;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // number layout changes with the geometry, so held numbers are dropped
    task automatic configure(input logic [NUM_W-1:0] ppg, input logic [NUM_W-1:0] gc,
                             input logic [NUM_W-1:0] ff);
        write_reg(CFG_PER_GROUP, ppg);
        write_reg(CFG_GROUPS, gc);
        write_reg(CFG_FIRST_FREE, ff);
        held_inodes.delete();
    endtask

    // send one request word; valid stays up unless a gap is taken
    task automatic send_request(input logic fn, input logic [3:0] sg,
                                input logic [NUM_W-1:0] rel, output reply_t r);
        if (traffic_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, rel, sg};
        s_tuser <= fn;
        do
            @(posedge clk);
        while (!s_tready);
        r = apply_inode_request(fn, sg, rel);
        grant_replies.push_back(r);
    endtask

    // drop valid and wait for every reply before touching registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (grant_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random mix: releases of held numbers, stray releases, allocations
    task automatic run_traffic(input int unsigned items, input int unsigned free_pct,
                              input bit give_back);
        reply_t      r;
        int unsigned pick;
        int unsigned num;
        repeat (items)
        begin
            if (held_inodes.size() != 0 && $urandom_range(0, 99) < free_pct)
            begin
                pick = $urandom_range(0, held_inodes.size() - 1);
                num = held_inodes[pick];
                held_inodes.delete(pick);
                send_request(FUNC_FREE, 4'($urandom_range(0, 15)), NUM_W'(num), r);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                // stray release anywhere in the field or near the reserved floor
                num = $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 40);
                send_request(FUNC_FREE, 4'($urandom_range(0, 15)), NUM_W'(num), r);
            end
            else
            begin
                send_request(FUNC_ALLOC, 4'($urandom_range(0, 15)),
                             NUM_W'($urandom_range(0, 32767)), r);
                if (r.status == STATUS_OK)
                    held_inodes.push_back(r.granted);
            end
        end
        // hand every held number back so later geometries start clean
        if (give_back)
        begin
            while (held_inodes.size() != 0)
            begin
                num = held_inodes.pop_back();
                send_request(FUNC_FREE, 4'($urandom_range(0, 15)), NUM_W'(num), r);
            end
        end
    endtask

    // reset geometry: first and last group, double free, zero and ignored releases
    task automatic test_default_geometry();
        reply_t r;
        send_request(FUNC_ALLOC, 4'd0, '0, r);
        send_request(FUNC_ALLOC, 4'd15, 15'h7FFF, r);
        send_request(FUNC_ALLOC, 4'd15, '0, r);
        send_request(FUNC_FREE, 4'd0, 15'd15361, r);
        send_request(FUNC_FREE, 4'd15, 15'd15361, r);
        send_request(FUNC_FREE, 4'd0, 15'd0, r);
        send_request(FUNC_FREE, 4'd0, 15'd1, r);
        send_request(FUNC_FREE, 4'd0, 15'h7FFF, r);
        wait_idle();
    endtask

    // tiny geometry: wrap-around search, start group past the end, double free
    task automatic test_small_geometry_wrap();
        reply_t r;
        configure(15'd2, 15'd3, 15'd1);
        send_request(FUNC_ALLOC, 4'd2, '0, r);
        send_request(FUNC_ALLOC, 4'd2, '0, r);
        send_request(FUNC_ALLOC, 4'd2, '0, r);
        send_request(FUNC_ALLOC, 4'd9, '0, r);
        send_request(FUNC_ALLOC, 4'd1, '0, r);
        send_request(FUNC_ALLOC, 4'd0, '0, r);
        send_request(FUNC_FREE, 4'd0, 15'd3, r);
        send_request(FUNC_ALLOC, 4'd0, '0, r);
        send_request(FUNC_FREE, 4'd0, 15'd4, r);
        send_request(FUNC_FREE, 4'd0, 15'd4, r);
        wait_idle();
    endtask

    // zero and oversized register values, spare register index
    task automatic test_register_extremes();
        reply_t r;
        configure(15'd0, 15'd0, 15'h7FFF);
        send_request(FUNC_ALLOC, 4'd3, '0, r);
        send_request(FUNC_FREE, 4'd0, 15'h7FFF, r);
        wait_idle();
        write_reg(2'd3, 15'h1234);
        configure(15'h7FFF, 15'h7FFF, 15'd1);
        send_request(FUNC_ALLOC, 4'd15, '0, r);
        send_request(FUNC_FREE, 4'd0, 15'd1, r);
        wait_idle();
    endtask

    // random traffic over a spread of geometries
    task automatic test_random_traffic();
        configure(15'd1024, 15'd16, 15'd11);
        run_traffic(200, 30, 1'b1);
        wait_idle();
        configure(15'd1, 15'd1, 15'd1);
        run_traffic(60, 40, 1'b1);
        wait_idle();
        configure(15'd7, 15'd5, 15'd3);
        run_traffic(200, 40, 1'b1);
        wait_idle();
        configure(15'd33, 15'd4, 15'd40);
        run_traffic(200, 45, 1'b1);
        wait_idle();
        repeat (3)
        begin
            configure(NUM_W'($urandom_range(1, 64)), NUM_W'($urandom_range(1, 16)),
                      NUM_W'($urandom_range(1, 20)));
            run_traffic(100, 45, 1'b1);
            wait_idle();
        end
        configure(15'd0, 15'd16, 15'd1);
        run_traffic(80, 40, 1'b1);
        wait_idle();
    endtask

    // shrink the group count under a loaded bitmap, then grow it back
    task automatic test_shrunk_group_count();
        configure(15'd64, 15'd16, 15'd1);
        run_traffic(150, 10, 1'b0);
        wait_idle();
        write_reg(CFG_GROUPS, 15'd2);
        run_traffic(100, 40, 1'b0);
        wait_idle();
        write_reg(CFG_GROUPS, 15'd16);
        run_traffic(20, 50, 1'b1);
        wait_idle();
    endtask

    // last stretch with both sides always ready
    task automatic test_streaming_no_gaps();
        traffic_gaps = 1'b0;
        configure(15'd5, 15'd16, 15'd1);
        run_traffic(150, 45, 1'b1);
        wait_idle();
    endtask

    // result checker and receiver back-pressure
    initial
    begin
        reply_t want;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (grant_replies.size() == 0)
                begin
                    $display("%0t: unexpected word status %0d granted %0d free %0d",
                             $time, m_tuser, m_tdata[14:0], m_tdata[29:15]);
                    error_count++;
                end
                else
                begin
                    want = grant_replies.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[14:0] !== want.granted)
                    begin
                        $display("%0t: granted_number expected %0d actual %0d",
                                 $time, want.granted, m_tdata[14:0]);
                        error_count++;
                    end
                    if (m_tdata[29:15] !== want.free_left)
                    begin
                        $display("%0t: free_total expected %0d actual %0d",
                                 $time, want.free_left, m_tdata[29:15]);
                        error_count++;
                    end
                end
            end
            // random stall bursts, started only while traffic gaps are enabled
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (traffic_gaps && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // main sequence
    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_PER_GROUP;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= FUNC_ALLOC;
        reset_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // bitmap clearing sweep runs before the first request is taken
        do
            @(posedge clk);
        while (!s_tready);

        test_default_geometry();
        test_small_geometry_wrap();
        test_register_extremes();
        test_random_traffic();
        test_shrunk_group_count();
        test_streaming_no_gaps();

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
